>>> src/smst_pkg.sv
// Shared types and constants for the 3x3 smoothing stencil.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package smst_pkg;

    // configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER = 2'd0,
        REG_EDGE   = 2'd1,
        REG_CENTER = 2'd2,
        REG_SIZE   = 2'd3
    } t_reg_idx;

    // coefficients are signed Q1.14
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;

    // reset weights: 0.05, 0.1 and 0.4 in Q1.14
    localparam logic signed [COEF_W-1:0] CORNER_RESET = 16'sd819;
    localparam logic signed [COEF_W-1:0] EDGE_RESET   = 16'sd1638;
    localparam logic signed [COEF_W-1:0] CENTER_RESET = 16'sd6554;

    localparam int SIZE_W     = 13;
    localparam int SIZE_RESET = 4096;
    localparam int SIZE_MIN   = 3;

endpackage

`default_nettype wire

>>> src/smst_ifs.sv
// Valid/ready channel interfaces for the 3x3 smoothing stencil:
// pixel input, filtered result output and configuration writes. Uses smst_pkg.
`default_nettype none

interface smst_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   start_of_frame;

    modport source (output valid, output sample, output start_of_frame, input ready);
    modport sink   (input valid, input sample, input start_of_frame, output ready);
endinterface

interface smst_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COORD_BITS  = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] smoothed;
    logic [COORD_BITS-1:0]  out_row;
    logic [COORD_BITS-1:0]  out_col;
    logic                   saturated;
    logic                   last;

    modport source (output valid, output smoothed, output out_row, output out_col,
                    output saturated, output last, input ready);
    modport sink   (input valid, input smoothed, input out_row, input out_col,
                    input saturated, input last, output ready);
endinterface

interface smst_cfg_if;
    import smst_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/smoothing_3x3_stencil.sv
// 3x3 smoothing stencil, top level. Depends on smst_pkg, the channel
// interfaces in smst_ifs.sv and the line store RAM smst_ram.
`default_nettype none

// Streams a square image in raster order, one sample per cycle, and returns
// corner*diagonals + edge*sides + center*centre for every interior position,
// rounded half up and clamped to the sample range (saturated flags a clamp).
// Border positions produce no result; last marks the centre at (N-2, N-2).
// Throughput is one sample per clock; the sample that completes a window
// goes through the stages in order to the output register (sample
// capture with line store read, window shift, neighbour sums, multiply; the
// accumulate/round feeds the output register). A held-off output stalls the
// whole pipeline and the input. The two line stores share one RAM of
// MAX_SIZE words whose registered read port is read once per sample.
// start_of_frame restarts the position at (0, 0); without it the position
// wraps after (N-1, N-1). Write configuration only while the pipeline is
// empty; image_size is clamped to 3..MAX_SIZE.
module smoothing_3x3_stencil #(
    parameter int MAX_SIZE    = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    smst_in_if.sink        i_pix,
    smst_out_if.source     o_res,
    smst_cfg_if.sink       i_cfg
);
    import smst_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_SIZE);
    localparam int NW   = CW + 1;
    localparam int SUMW = SB + 2;
    localparam int PW   = SB + 3 + COEF_W;
    localparam int AW   = PW + 2;
    localparam int SIZE_RST_EFF = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
    localparam logic signed [AW-1:0] RND  = AW'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [AW-1:0] SMAX = (AW'(1) <<< SB) - AW'(1);

    // configuration
    logic signed [COEF_W-1:0] r_corner, r_edge, r_center;
    logic [NW-1:0]            r_size;
    logic [SIZE_W-1:0]        cfg_size;
    logic [NW-1:0]            cfg_size_eff;

    assign i_cfg.ready = 1'b1;
    assign cfg_size    = i_cfg.data[SIZE_W-1:0];

    always_comb begin
        if (32'(cfg_size) > MAX_SIZE) begin
            cfg_size_eff = NW'(MAX_SIZE);
        end else if (32'(cfg_size) < SIZE_MIN) begin
            cfg_size_eff = NW'(SIZE_MIN);
        end else begin
            cfg_size_eff = NW'(cfg_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= CORNER_RESET;
            r_edge   <= EDGE_RESET;
            r_center <= CENTER_RESET;
            r_size   <= NW'(SIZE_RST_EFF);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_CORNER: r_corner <= i_cfg.data[COEF_W-1:0];
                REG_EDGE:   r_edge   <= i_cfg.data[COEF_W-1:0];
                REG_CENTER: r_center <= i_cfg.data[COEF_W-1:0];
                REG_SIZE:   r_size   <= cfg_size_eff;
                default: ;
            endcase
        end
    end

    // whole pipeline advances together when the output register is free
    logic adv, pix_acc;
    logic r_out_valid;

    assign adv         = !r_out_valid || o_res.ready;
    assign pix_acc     = i_pix.valid && adv;
    assign i_pix.ready = adv;

    // position tracking at accept
    logic [CW-1:0] r_row, r_col, n_row, n_col;
    logic [CW-1:0] cur_row, cur_col;
    logic [NW-1:0] row_p1, col_p1, size_m1;
    logic          cur_prod, cur_last;

    always_comb begin
        cur_row = i_pix.start_of_frame ? '0 : r_row;
        cur_col = i_pix.start_of_frame ? '0 : r_col;
        row_p1  = {1'b0, cur_row} + NW'(1);
        col_p1  = {1'b0, cur_col} + NW'(1);
        size_m1 = r_size - NW'(1);
        cur_prod = (cur_row >= CW'(2)) && (cur_col >= CW'(2))
                && ({1'b0, cur_row} <= size_m1) && ({1'b0, cur_col} <= size_m1);
        cur_last = ({1'b0, cur_row} == size_m1) && ({1'b0, cur_col} == size_m1);
        if (col_p1 >= r_size) begin
            n_col = '0;
            n_row = (row_p1 >= r_size) ? '0 : row_p1[CW-1:0];
        end else begin
            n_col = col_p1[CW-1:0];
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (pix_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // stage 1: line store read in flight
    logic          r_s1_valid, r_s1_prod, r_s1_last;
    logic [SB-1:0] r_s1_sample;
    logic [CW-1:0] r_s1_col, r_s1_orow, r_s1_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_sample <= i_pix.sample;
            r_s1_col    <= cur_col;
            r_s1_prod   <= cur_prod;
            r_s1_last   <= cur_last;
            r_s1_orow   <= cur_row - CW'(1);
            r_s1_ocol   <= cur_col - CW'(1);
        end
    end

    // line stores: upper half older row, lower half newer row
    logic [2*SB-1:0] ls_rdata;
    logic [SB-1:0]   ls_top, ls_mid;
    logic            ls_we;

    assign ls_top = ls_rdata[2*SB-1:SB];
    assign ls_mid = ls_rdata[SB-1:0];
    assign ls_we  = adv && r_s1_valid;

    smst_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_SIZE)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (r_s1_col),
        .i_wdata ({ls_mid, r_s1_sample}),
        .i_re    (pix_acc),
        .i_raddr (cur_col),
        .o_rdata (ls_rdata)
    );

    // stage 2: window shift
    logic [SB-1:0] r_win [9];
    logic          r_s2_valid, r_s2_last;
    logic [CW-1:0] r_s2_orow, r_s2_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3+0] <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= ls_top;
            r_win[5] <= ls_mid;
            r_win[8] <= r_s1_sample;
        end
        if (adv) begin
            r_s2_last <= r_s1_last;
            r_s2_orow <= r_s1_orow;
            r_s2_ocol <= r_s1_ocol;
        end
    end

    // stage 3: neighbour sums
    logic            r_s3_valid, r_s3_last;
    logic [CW-1:0]   r_s3_orow, r_s3_ocol;
    logic [SUMW-1:0] r_diag, r_side;
    logic [SB-1:0]   r_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_diag    <= SUMW'(r_win[0]) + SUMW'(r_win[2]) + SUMW'(r_win[6])
                       + SUMW'(r_win[8]);
            r_side    <= SUMW'(r_win[1]) + SUMW'(r_win[3]) + SUMW'(r_win[5])
                       + SUMW'(r_win[7]);
            r_ctr     <= r_win[4];
            r_s3_last <= r_s2_last;
            r_s3_orow <= r_s2_orow;
            r_s3_ocol <= r_s2_ocol;
        end
    end

    // stage 4: weighted products
    logic                 r_s4_valid, r_s4_last;
    logic [CW-1:0]        r_s4_orow, r_s4_ocol;
    logic signed [PW-1:0] r_p_diag, r_p_side, r_p_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_diag  <= r_corner * $signed({1'b0, r_diag});
            r_p_side  <= r_edge * $signed({1'b0, r_side});
            r_p_ctr   <= r_center * $signed({1'b0, r_ctr});
            r_s4_last <= r_s3_last;
            r_s4_orow <= r_s3_orow;
            r_s4_ocol <= r_s3_ocol;
        end
    end

    // accumulate, round half up, clamp
    logic signed [AW-1:0] biased, quot;
    logic [SB-1:0]        res_val;
    logic                 res_sat;

    always_comb begin
        biased = AW'(r_p_diag) + AW'(r_p_side) + AW'(r_p_ctr) + RND;
        quot   = biased >>> COEF_FRAC;
        if (biased[AW-1]) begin
            res_val = '0;
            res_sat = 1'b1;
        end else if (quot > SMAX) begin
            res_val = '1;
            res_sat = 1'b1;
        end else begin
            res_val = quot[SB-1:0];
            res_sat = 1'b0;
        end
    end

    // output register
    logic [SB-1:0] r_out_smoothed;
    logic [CW-1:0] r_out_row, r_out_col;
    logic          r_out_sat, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_smoothed <= res_val;
            r_out_sat      <= res_sat;
            r_out_last     <= r_s4_last;
            r_out_row      <= r_s4_orow;
            r_out_col      <= r_s4_ocol;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.smoothed  = r_out_smoothed;
    assign o_res.out_row   = r_out_row;
    assign o_res.out_col   = r_out_col;
    assign o_res.saturated = r_out_sat;
    assign o_res.last      = r_out_last;

endmodule

`default_nettype wire

>>> src/smst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
`default_nettype none

module smst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
